// ===== rtl/core/segment_intersection_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Segment intersection unit assertion macros
// Concurrent assertion shorthands, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication under reset
`define SIU_ASSERT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("segment_intersection_unit assertion failed");
// next-cycle implication under reset
`define SIU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("segment_intersection_unit assertion failed");
`else
`define SIU_ASSERT(lbl, clk, rstn, ante, cons)
`define SIU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/siu_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection unit package
// Beat types and result kind codes shared by the unit.
// ----------------------------------------------------------------------------
package siu_pkg;

	localparam int FIELD_W = 16;
	localparam int POINT_W = 32;

	// result kind codes
	localparam logic [1:0] KIND_HIT        = 2'd0;
	localparam logic [1:0] KIND_PARALLEL   = 2'd1;
	localparam logic [1:0] KIND_COINCIDENT = 2'd2;
	localparam logic [1:0] KIND_MISS       = 2'd3;

	typedef struct packed {
		logic signed [FIELD_W-1:0] a_start_x;
		logic signed [FIELD_W-1:0] a_start_y;
		logic signed [FIELD_W-1:0] a_end_x;
		logic signed [FIELD_W-1:0] a_end_y;
		logic signed [FIELD_W-1:0] b_start_x;
		logic signed [FIELD_W-1:0] b_start_y;
		logic signed [FIELD_W-1:0] b_end_x;
		logic signed [FIELD_W-1:0] b_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [POINT_W-1:0] cross_x;
		logic signed [POINT_W-1:0] cross_y;
	} cross_res_t;

endpackage

// ===== rtl/core/segment_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// Segment intersection unit
// Tests two segments for contact with four orientation tests and solves the
// crossing point by Cramer's rule with a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//  in channel (in_valid/in_ready/in_data) takes one beat per segment pair:
//  two segments as signed integer endpoints. out channel
//  (out_valid/out_ready/out_data) returns one beat per pair: the kind code
//  and, for a proper crossing, the point in signed fixed point with
//  FRAC_BITS fraction bits, rounded toward zero and saturated to 32 bits.
//  From acceptance to out_valid a pair passes seven arithmetic stages, 32
//  divider stages (one quotient bit per stage for x and y in parallel)
//  and the output register. Throughput is one pair per cycle unless the
//  output stalls. All stages advance together; when the receiver holds
//  out_ready low with a beat waiting, the whole pipeline freezes, empty
//  slots included, and in_ready drops until the beat is taken. Reset
//  clears every valid bit; no item is lost or repeated across a stall.
// ----------------------------------------------------------------------------
`include "segment_intersection_unit_macros.svh"

module segment_intersection_unit
	import siu_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  seg_pair_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output cross_res_t out_data
);

	localparam int CW   = COORD_BITS;
	localparam int DW   = CW + 1;
	localparam int SQW  = 2 * DW;
	localparam int PW   = SQW + 1;
	localparam int DDW  = 2 * CW + 2;
	localparam int XW   = DDW + DW + 1;
	localparam int NW   = XW + FRAC_BITS;
	localparam int MW   = (NW > PW) ? NW : PW;
	localparam int QW   = POINT_W;

	function automatic logic signed [CW-1:0] coord_of(input logic [FIELD_W-1:0] f);
		logic [CW+FIELD_W-1:0] z;
		z = {{CW{1'b0}}, f};
		return z[CW-1:0];
	endfunction

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: coordinates and differences ----------------
	logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	assign ax0 = coord_of(in_data.a_start_x);
	assign ay0 = coord_of(in_data.a_start_y);
	assign ax1 = coord_of(in_data.a_end_x);
	assign ay1 = coord_of(in_data.a_end_y);
	assign bx0 = coord_of(in_data.b_start_x);
	assign by0 = coord_of(in_data.b_start_y);
	assign bx1 = coord_of(in_data.b_end_x);
	assign by1 = coord_of(in_data.b_end_y);

	logic                 v_s1;
	logic signed [CW-1:0] ax0_s1, ay0_s1, bx0_s1, by0_s1;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, n0x_s1, n1x_s1;
	logic signed [DW-1:0] ex_s1 [4];
	logic signed [DW-1:0] ey_s1 [4];

	// latch the pair as differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax0_s1   <= ax0;
			ay0_s1   <= ay0;
			bx0_s1   <= bx0;
			by0_s1   <= by0;
			dax_s1   <= DW'(ax1) - DW'(ax0);
			day_s1   <= DW'(ay1) - DW'(ay0);
			dbx_s1   <= DW'(bx1) - DW'(bx0);
			dby_s1   <= DW'(by1) - DW'(by0);
			n0x_s1   <= DW'(ay0) - DW'(ay1);
			n1x_s1   <= DW'(by0) - DW'(by1);
			ex_s1[0] <= DW'(bx0) - DW'(ax0);
			ey_s1[0] <= DW'(by0) - DW'(ay0);
			ex_s1[1] <= DW'(bx1) - DW'(ax0);
			ey_s1[1] <= DW'(by1) - DW'(ay0);
			ex_s1[2] <= DW'(ax0) - DW'(bx0);
			ey_s1[2] <= DW'(ay0) - DW'(by0);
			ex_s1[3] <= DW'(ax1) - DW'(bx0);
			ey_s1[3] <= DW'(ay1) - DW'(by0);
		end
	end

	// ---------------- stage 2: products ----------------
	logic signed [DW-1:0] dx1 [4];
	logic signed [DW-1:0] dy1 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dx1[i] = (i < 2) ? dax_s1 : dbx_s1;
			dy1[i] = (i < 2) ? day_s1 : dby_s1;
		end
	end

	logic                  v_s2;
	logic signed [SQW-1:0] l_s2 [4];
	logic signed [SQW-1:0] r_s2 [4];
	logic signed [SQW-1:0] xp_s2 [4];
	logic signed [SQW-1:0] yp_s2 [4];
	logic signed [PW-1:0]  far_s2 [4];
	logic signed [PW-1:0]  sa_s2, sb_s2;
	logic signed [SQW-1:0] pa0_s2, pa1_s2, pb0_s2, pb1_s2, dp0_s2, dp1_s2;
	logic signed [DW-1:0]  n0x_s2, n0y_s2, n1x_s2, n1y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// form the cross, dot and square products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				l_s2[i]   <= dx1[i] * ey_s1[i];
				r_s2[i]   <= dy1[i] * ex_s1[i];
				xp_s2[i]  <= dx1[i] * ex_s1[i];
				yp_s2[i]  <= dy1[i] * ey_s1[i];
				far_s2[i] <= ex_s1[i] * ex_s1[i] + ey_s1[i] * ey_s1[i];
			end
			sa_s2  <= dax_s1 * dax_s1 + day_s1 * day_s1;
			sb_s2  <= dbx_s1 * dbx_s1 + dby_s1 * dby_s1;
			pa0_s2 <= n0x_s1 * ax0_s1;
			pa1_s2 <= dax_s1 * ay0_s1;
			pb0_s2 <= n1x_s1 * bx0_s1;
			pb1_s2 <= dbx_s1 * by0_s1;
			dp0_s2 <= dax_s1 * n1x_s1;
			dp1_s2 <= n0x_s1 * dbx_s1;
			n0x_s2 <= n0x_s1;
			n0y_s2 <= dax_s1;
			n1x_s2 <= n1x_s1;
			n1y_s2 <= dbx_s1;
		end
	end

	// ---------------- stage 3: orientation, offsets, determinant ----------------
	logic [3:0] opos, oneg;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic gt, lt, col, behind, far;
			gt      = l_s2[i] > r_s2[i];
			lt      = l_s2[i] < r_s2[i];
			col     = !gt && !lt;
			behind  = (xp_s2[i] < 0) || (yp_s2[i] < 0);
			far     = ((i < 2) ? sa_s2 : sb_s2) < far_s2[i];
			opos[i] = gt || (col && !behind && far);
			oneg[i] = lt || (col && behind);
		end
	end

	logic                  v_s3, meet_s3;
	logic signed [DDW-1:0] d0_s3, d1_s3;
	logic signed [PW-1:0]  den_s3;
	logic signed [DW-1:0]  n0x_s3, n0y_s3, n1x_s3, n1y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meet_s3 <= !((opos[0] && opos[1]) || (oneg[0] && oneg[1])) &&
			           !((opos[2] && opos[3]) || (oneg[2] && oneg[3]));
			d0_s3   <= pa0_s2 + pa1_s2;
			d1_s3   <= pb0_s2 + pb1_s2;
			den_s3  <= dp0_s2 - dp1_s2;
			n0x_s3  <= n0x_s2;
			n0y_s3  <= n0y_s2;
			n1x_s3  <= n1x_s2;
			n1y_s3  <= n1y_s2;
		end
	end

	// ---------------- stage 4: numerator products ----------------
	logic                   v_s4, meet_s4;
	logic signed [XW-2:0]   mxa_s4, mxb_s4, mya_s4, myb_s4;
	logic signed [PW-1:0]   den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mxa_s4  <= d1_s3 * n0y_s3;
			mxb_s4  <= d0_s3 * n1y_s3;
			mya_s4  <= d0_s3 * n1x_s3;
			myb_s4  <= d1_s3 * n0x_s3;
			den_s4  <= den_s3;
			meet_s4 <= meet_s3;
		end
	end

	// ---------------- stage 5: numerators, kind, divisor magnitude ----------------
	logic signed [XW-1:0] xn, yn;
	assign xn = XW'(mxa_s4) - XW'(mxb_s4);
	assign yn = XW'(mya_s4) - XW'(myb_s4);

	logic                 v_s5, dneg_s5;
	logic [1:0]           kind_s5;
	logic signed [XW-1:0] xn_s5, yn_s5;
	logic [PW-1:0]        dmag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s5   <= xn;
			yn_s5   <= yn;
			dneg_s5 <= den_s4 < 0;
			// a zero divisor is replaced so the divider stays defined
			if (den_s4 == 0) begin
				dmag_s5 <= PW'(1);
			end else if (den_s4 < 0) begin
				dmag_s5 <= PW'(-den_s4);
			end else begin
				dmag_s5 <= PW'(den_s4);
			end
			if (!meet_s4) begin
				kind_s5 <= KIND_MISS;
			end else if (den_s4 == 0) begin
				kind_s5 <= (xn == 0) ? KIND_COINCIDENT : KIND_PARALLEL;
			end else begin
				kind_s5 <= KIND_HIT;
			end
		end
	end

	// ---------------- stage 6: scaled numerator magnitudes ----------------
	logic signed [XW:0] xe, ye;
	logic [XW:0]        xm, ym;
	assign xe = {xn_s5[XW-1], xn_s5};
	assign ye = {yn_s5[XW-1], yn_s5};
	assign xm = (xe < 0) ? -xe : xe;
	assign ym = (ye < 0) ? -ye : ye;

	logic          v_s6, negx_s6, negy_s6;
	logic [1:0]    kind_s6;
	logic [NW-1:0] nx_s6, ny_s6;
	logic [PW-1:0] dmag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s6   <= NW'(xm) << FRAC_BITS;
			ny_s6   <= NW'(ym) << FRAC_BITS;
			negx_s6 <= xn_s5[XW-1] ^ dneg_s5;
			negy_s6 <= yn_s5[XW-1] ^ dneg_s5;
			dmag_s6 <= dmag_s5;
			kind_s6 <= kind_s5;
		end
	end

	// ---------------- stage 7: overflow check and divider load ----------------
	logic [NW+31:0] nxe, nye;
	assign nxe = {32'd0, nx_s6};
	assign nye = {32'd0, ny_s6};

	logic          dv    [33];
	logic [1:0]    dkind [33];
	logic          dnegx [33];
	logic          dnegy [33];
	logic          dovfx [33];
	logic          dovfy [33];
	logic [PW-1:0] dm    [33];
	logic [PW-1:0] rx    [33];
	logic [PW-1:0] ry    [33];
	logic [QW-1:0] lqx   [33];
	logic [QW-1:0] lqy   [33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (en) begin
			dv[0] <= v_s6;
		end
	end

	// quotient overflows 32 bits when the numerator's high part reaches the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			dovfx[0] <= MW'(nxe[NW+31:32]) >= MW'(dmag_s6);
			dovfy[0] <= MW'(nye[NW+31:32]) >= MW'(dmag_s6);
			rx[0]    <= PW'(nxe[NW+31:32]);
			ry[0]    <= PW'(nye[NW+31:32]);
			lqx[0]   <= nxe[31:0];
			lqy[0]   <= nye[31:0];
			dm[0]    <= dmag_s6;
			dnegx[0] <= negx_s6;
			dnegy[0] <= negy_s6;
			dkind[0] <= kind_s6;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [PW:0]   tx, ty;
		logic          gex, gey;
		logic [PW-1:0] nrx, nry;

		assign tx  = {rx[k], lqx[k][QW-1]};
		assign ty  = {ry[k], lqy[k][QW-1]};
		assign gex = tx >= {1'b0, dm[k]};
		assign gey = ty >= {1'b0, dm[k]};
		assign nrx = gex ? PW'(tx - {1'b0, dm[k]}) : tx[PW-1:0];
		assign nry = gey ? PW'(ty - {1'b0, dm[k]}) : ty[PW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[k+1] <= 1'b0;
			end else if (en) begin
				dv[k+1] <= dv[k];
			end
		end

		// shift the next numerator bit in and the quotient bit out
		always_ff @(posedge clk) begin
			if (en) begin
				rx[k+1]    <= nrx;
				ry[k+1]    <= nry;
				lqx[k+1]   <= {lqx[k][QW-2:0], gex};
				lqy[k+1]   <= {lqy[k][QW-2:0], gey};
				dm[k+1]    <= dm[k];
				dnegx[k+1] <= dnegx[k];
				dnegy[k+1] <= dnegy[k];
				dovfx[k+1] <= dovfx[k];
				dovfy[k+1] <= dovfy[k];
				dkind[k+1] <= dkind[k];
			end
		end
	end

	// ---------------- output: saturate, sign, register ----------------
	logic [QW-1:0] limx, limy, mx, my;
	assign limx = dnegx[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign limy = dnegy[QW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign mx   = (dovfx[QW] || (lqx[QW] > limx)) ? limx : lqx[QW];
	assign my   = (dovfy[QW] || (lqy[QW] > limy)) ? limy : lqy[QW];

	cross_res_t out_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.kind <= dkind[QW];
			if (dkind[QW] == KIND_HIT) begin
				out_q.cross_x <= dnegx[QW] ? -mx : mx;
				out_q.cross_y <= dnegy[QW] ? -my : my;
			end else begin
				out_q.cross_x <= '0;
				out_q.cross_y <= '0;
			end
		end
	end

	// ---------------- assertions ----------------
	`SIU_ASSERT(a_miss_zero, clk, arst_n, out_valid && out_q.kind != KIND_HIT, out_q.cross_x == 0 && out_q.cross_y == 0)
	`SIU_ASSERT(a_div_nonzero, clk, arst_n, dv[0], dm[0] != 0)
	`SIU_ASSERT(a_rem_x_below, clk, arst_n, dv[QW] && !dovfx[QW], rx[QW] < dm[QW])
	`SIU_ASSERT(a_rem_y_below, clk, arst_n, dv[QW] && !dovfy[QW], ry[QW] < dm[QW])
	`SIU_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready && dkind[QW] != out_q.kind, out_valid && !$stable(dkind[QW]) == 1'b0)

endmodule
